### src/ffha_pkg.sv
// Shared types, constants and codes of the first-fit heap allocator.
package ffha_pkg;

	localparam int ARENA_BYTES  = 65536;
	localparam int HEADER_BYTES = 24;
	localparam int MAX_BLOCKS   = 256;

	localparam int SLOT_W   = $clog2(MAX_BLOCKS);
	localparam int PTR_W    = SLOT_W + 1;
	localparam int CHUNK    = (MAX_BLOCKS >= 64) ? 16 : MAX_BLOCKS / 2;
	localparam int NCHUNK   = MAX_BLOCKS / CHUNK;
	localparam int CHUNK_W  = $clog2(NCHUNK);
	localparam int CHUNK_BW = $clog2(CHUNK);
	localparam int LIMIT_W  = 17;
	localparam int NEED_W   = 18;

	localparam logic [PTR_W-1:0] NIL_PTR = PTR_W'(MAX_BLOCKS);

	localparam logic [1:0] CMD_ALLOC   = 2'd0;
	localparam logic [1:0] CMD_FREE    = 2'd1;
	localparam logic [1:0] CMD_REALLOC = 2'd2;
	localparam logic [1:0] CMD_UNUSED  = 2'd3;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_ZERO_SIZE  = 3'd1;
	localparam logic [2:0] ST_EXHAUSTED  = 3'd2;
	localparam logic [2:0] ST_TABLE_FULL = 3'd3;
	localparam logic [2:0] ST_UNKNOWN    = 3'd4;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] request_size;
		logic [15:0] block_address;
	} req_t;

	typedef struct packed {
		logic [15:0] result_address;
		logic [2:0]  status;
		logic [15:0] copy_source;
		logic [15:0] copy_length;
	} rsp_t;

	typedef struct packed {
		logic [15:0]      start;
		logic [15:0]      size;
		logic             free;
		logic [PTR_W-1:0] next;
	} desc_t;

	typedef struct packed {
		logic              scan;
		logic              set;
		logic [SLOT_W-1:0] set_idx;
		logic              clr;
		logic [SLOT_W-1:0] clr_idx;
	} slot_ctl_t;

	typedef struct packed {
		logic              done;
		logic              found;
		logic [SLOT_W-1:0] idx;
	} slot_res_t;

endpackage

### src/ffha_slot_finder.sv
// Descriptor slot occupancy bits with a chunked first-free search.
module ffha_slot_finder (
	input  logic                clk,
	input  logic                arst_n,
	input  ffha_pkg::slot_ctl_t ctl,
	output ffha_pkg::slot_res_t res
);
	import ffha_pkg::*;

	logic [MAX_BLOCKS-1:0] used_q;
	logic                  busy_q;
	logic [CHUNK_W-1:0]    chunk_q;
	logic [CHUNK-1:0]      bits;
	logic                  hit;
	logic [CHUNK_BW-1:0]   pos;
	logic                  last_chunk;

	always_comb begin
		bits = used_q[chunk_q * CHUNK +: CHUNK];
		hit  = 1'b0;
		pos  = '0;
		for (int i = CHUNK - 1; i >= 0; i--) begin
			if (!bits[i]) begin
				hit = 1'b1;
				pos = CHUNK_BW'(i);
			end
		end
	end

	assign last_chunk = (chunk_q == CHUNK_W'(NCHUNK - 1));
	assign res.done   = busy_q && (hit || last_chunk);
	assign res.found  = busy_q && hit;
	assign res.idx    = {chunk_q, pos};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			busy_q  <= 1'b0;
			chunk_q <= '0;
		end else begin
			if (ctl.set) used_q[ctl.set_idx] <= 1'b1;
			if (ctl.clr) used_q[ctl.clr_idx] <= 1'b0;
			if (ctl.scan) begin
				busy_q  <= 1'b1;
				chunk_q <= '0;
			end else if (busy_q) begin
				if (hit || last_chunk) busy_q <= 1'b0;
				else chunk_q <= chunk_q + CHUNK_W'(1);
			end
		end
	end

endmodule

### src/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator: sequencer, descriptor memory, heap registers.
// Each walk (find, first fit, merge) reads the chain blocks it visits one after another,
//   and each free-slot search scans the slot bits in chunks of 16 slots.
// Throughput: one request at a time; a new request is accepted only in the idle state.
// Reset: chain empty, heap break zero, heap_limit 65536, all slots free; the descriptor
//   memory itself is not cleared, since only slots linked on the chain are read.
module first_fit_heap_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  ffha_pkg::req_t              in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output ffha_pkg::rsp_t              out_data,
	input  logic                        cfg_wr_en,
	input  logic [ffha_pkg::LIMIT_W-1:0] cfg_wr_data
);
	import ffha_pkg::*;

	typedef enum logic [17:0] {
		S_IDLE   = 18'h00001,
		S_F_W    = 18'h00002,
		S_F_C    = 18'h00004,
		S_A_W    = 18'h00008,
		S_A_C    = 18'h00010,
		S_A_SLOT = 18'h00020,
		S_A_SPL  = 18'h00040,
		S_GROW   = 18'h00080,
		S_G_SLOT = 18'h00100,
		S_G_LINK = 18'h00200,
		S_A_END  = 18'h00400,
		S_R_W    = 18'h00800,
		S_R_C    = 18'h01000,
		S_M_W    = 18'h02000,
		S_M_C0   = 18'h04000,
		S_M_W2   = 18'h08000,
		S_M_C1   = 18'h10000,
		S_DONE   = 18'h20000
	} state_t;

	localparam logic [16:0]       HDR17   = 17'(HEADER_BYTES);
	localparam logic [15:0]       HDR16   = 16'(HEADER_BYTES);
	localparam logic [NEED_W-1:0] HDRN    = NEED_W'(HEADER_BYTES);
	localparam logic [LIMIT_W-1:0] ARENA_L = LIMIT_W'(ARENA_BYTES);

	state_t              state_q;
	req_t                req_q;
	logic                realloc_q;
	logic [PTR_W-1:0]    ptr_q;
	logic [SLOT_W-1:0]   cur_q;
	logic [SLOT_W-1:0]   b_q;
	logic [SLOT_W-1:0]   s_q;
	logic [PTR_W-1:0]    last_q;
	desc_t               ent_q;
	desc_t               last_ent_q;
	desc_t               rd_q;
	logic [PTR_W-1:0]    head_q;
	logic [LIMIT_W-1:0]  break_q;
	logic [LIMIT_W-1:0]  limit_q;
	logic [NEED_W-1:0]   need_q;
	logic [15:0]         old_len_q;
	rsp_t                res_q;
	rsp_t                out_q;
	logic                out_valid_q;

	// descriptor memory: one write and one registered read per cycle
	desc_t               mem [MAX_BLOCKS];
	logic                mem_we;
	logic [SLOT_W-1:0]   mem_wa;
	desc_t               mem_wd;

	slot_ctl_t           slot_ctl;
	slot_res_t           slot_res;

	logic                rd_fit;
	logic                rd_split;
	logic                rd_match;
	logic                merge_ok;
	desc_t               merged;
	logic [NEED_W-1:0]   need;
	logic [LIMIT_W-1:0]  cap;
	logic                is_alloc;
	logic                done_fire;

	ffha_slot_finder u_slots (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (slot_ctl),
		.res    (slot_res)
	);

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_q <= mem[ptr_q[SLOT_W-1:0]];
	end

	assign rd_fit   = rd_q.free && (rd_q.size >= req_q.request_size);
	assign rd_split = {1'b0, rd_q.size} > ({1'b0, req_q.request_size} + HDR17);
	assign rd_match = ({1'b0, rd_q.start} + HDR17) == {1'b0, req_q.block_address};
	assign merge_ok = ent_q.free && rd_q.free;
	assign need     = {1'b0, break_q} + HDRN + {2'b00, req_q.request_size};
	assign cap      = (limit_q < ARENA_L) ? limit_q : ARENA_L;
	assign is_alloc = (in_data.command == CMD_ALLOC) ||
			((in_data.command == CMD_REALLOC) && (in_data.block_address == 16'd0));

	always_comb begin
		merged      = ent_q;
		merged.size = ent_q.size + HDR16 + rd_q.size;
		merged.next = rd_q.next;
	end

	// memory writes and slot bookkeeping, decoded from the sequencer state
	always_comb begin
		mem_we           = 1'b0;
		mem_wa           = ptr_q[SLOT_W-1:0];
		mem_wd           = rd_q;
		slot_ctl.scan    = 1'b0;
		slot_ctl.set     = 1'b0;
		slot_ctl.set_idx = slot_res.idx;
		slot_ctl.clr     = 1'b0;
		slot_ctl.clr_idx = ptr_q[SLOT_W-1:0];
		case (state_q)
			S_F_C: begin
				// free: mark the found block
				if (rd_match && (req_q.command == CMD_FREE)) begin
					mem_we      = 1'b1;
					mem_wd.free = 1'b1;
				end
			end
			S_A_C: begin
				if (rd_fit) begin
					if (rd_split) begin
						slot_ctl.scan = 1'b1;
					end else begin
						mem_we      = 1'b1;
						mem_wd.free = 1'b0;
					end
				end
			end
			S_A_SLOT: begin
				if (slot_res.done) begin
					mem_we = 1'b1;
					if (slot_res.found) begin
						// carve the surplus into a new free block
						mem_wa       = slot_res.idx;
						mem_wd.start = ent_q.start + HDR16 + req_q.request_size;
						mem_wd.size  = ent_q.size - req_q.request_size - HDR16;
						mem_wd.free  = 1'b1;
						mem_wd.next  = ent_q.next;
						slot_ctl.set = 1'b1;
					end else begin
						// no slot: grant the whole block
						mem_wa      = cur_q;
						mem_wd      = ent_q;
						mem_wd.free = 1'b0;
					end
				end
			end
			S_A_SPL: begin
				mem_we       = 1'b1;
				mem_wa       = cur_q;
				mem_wd.start = ent_q.start;
				mem_wd.size  = req_q.request_size;
				mem_wd.free  = 1'b0;
				mem_wd.next  = {1'b0, s_q};
			end
			S_GROW: begin
				if (need <= {1'b0, cap}) slot_ctl.scan = 1'b1;
			end
			S_G_SLOT: begin
				if (slot_res.done && slot_res.found) begin
					mem_we       = 1'b1;
					mem_wa       = slot_res.idx;
					mem_wd.start = break_q[15:0];
					mem_wd.size  = req_q.request_size;
					mem_wd.free  = 1'b0;
					mem_wd.next  = NIL_PTR;
					slot_ctl.set = 1'b1;
				end
			end
			S_G_LINK: begin
				// append the new block behind the old tail
				if (!last_q[SLOT_W]) begin
					mem_we      = 1'b1;
					mem_wa      = last_q[SLOT_W-1:0];
					mem_wd      = last_ent_q;
					mem_wd.next = {1'b0, s_q};
				end
			end
			S_R_C: begin
				mem_we      = 1'b1;
				mem_wd.free = 1'b1;
			end
			S_M_C1: begin
				if (merge_ok) begin
					mem_we       = 1'b1;
					mem_wa       = cur_q;
					mem_wd       = merged;
					slot_ctl.clr = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign done_fire = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= ARENA_L;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) limit_q <= cfg_wr_data;
			if (done_fire) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) out_q <= res_q;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			head_q    <= NIL_PTR;
			break_q   <= '0;
			realloc_q <= 1'b0;
			ptr_q     <= NIL_PTR;
			last_q    <= NIL_PTR;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q     <= in_data;
						res_q     <= '0;
						realloc_q <= 1'b0;
						ptr_q     <= head_q;
						last_q    <= NIL_PTR;
						if (is_alloc) begin
							if (in_data.request_size == 16'd0) begin
								res_q.status <= ST_ZERO_SIZE;
								state_q      <= S_DONE;
							end else if (head_q[SLOT_W]) begin
								state_q <= S_GROW;
							end else begin
								state_q <= S_A_W;
							end
						end else if (in_data.command == CMD_FREE ||
								in_data.command == CMD_REALLOC) begin
							if (in_data.command == CMD_FREE &&
									in_data.block_address == 16'd0) begin
								state_q <= S_DONE;
							end else if (head_q[SLOT_W]) begin
								res_q.status <= ST_UNKNOWN;
								state_q      <= S_DONE;
							end else begin
								state_q <= S_F_W;
							end
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_F_W: state_q <= S_F_C;
				S_F_C: begin
					if (rd_match) begin
						b_q <= ptr_q[SLOT_W-1:0];
						if (req_q.command == CMD_FREE) begin
							ptr_q   <= head_q;
							state_q <= S_M_W;
						end else if (rd_q.size >= req_q.request_size) begin
							res_q.result_address <= req_q.block_address;
							state_q              <= S_DONE;
						end else begin
							old_len_q <= rd_q.size;
							realloc_q <= 1'b1;
							ptr_q     <= head_q;
							last_q    <= NIL_PTR;
							state_q   <= S_A_W;
						end
					end else if (rd_q.next[SLOT_W]) begin
						res_q.status <= ST_UNKNOWN;
						state_q      <= S_DONE;
					end else begin
						ptr_q   <= rd_q.next;
						state_q <= S_F_W;
					end
				end
				S_A_W: state_q <= S_A_C;
				S_A_C: begin
					if (rd_fit) begin
						cur_q <= ptr_q[SLOT_W-1:0];
						ent_q <= rd_q;
						if (rd_split) begin
							state_q <= S_A_SLOT;
						end else begin
							res_q.result_address <= rd_q.start + HDR16;
							state_q              <= S_A_END;
						end
					end else begin
						last_q     <= ptr_q;
						last_ent_q <= rd_q;
						if (rd_q.next[SLOT_W]) begin
							state_q <= S_GROW;
						end else begin
							ptr_q   <= rd_q.next;
							state_q <= S_A_W;
						end
					end
				end
				S_A_SLOT: begin
					if (slot_res.done) begin
						res_q.result_address <= ent_q.start + HDR16;
						s_q                  <= slot_res.idx;
						state_q              <= slot_res.found ? S_A_SPL : S_A_END;
					end
				end
				S_A_SPL: state_q <= S_A_END;
				S_GROW: begin
					if (need > {1'b0, cap}) begin
						res_q.status <= ST_EXHAUSTED;
						state_q      <= S_A_END;
					end else begin
						need_q  <= need;
						state_q <= S_G_SLOT;
					end
				end
				S_G_SLOT: begin
					if (slot_res.done) begin
						if (slot_res.found) begin
							s_q     <= slot_res.idx;
							state_q <= S_G_LINK;
						end else begin
							res_q.status <= ST_TABLE_FULL;
							state_q      <= S_A_END;
						end
					end
				end
				S_G_LINK: begin
					if (last_q[SLOT_W]) head_q <= {1'b0, s_q};
					break_q              <= need_q[LIMIT_W-1:0];
					res_q.result_address <= break_q[15:0] + HDR16;
					state_q              <= S_A_END;
				end
				S_A_END: begin
					// a successful move frees the old block next
					if (realloc_q && res_q.status == ST_OK) begin
						res_q.copy_source <= req_q.block_address;
						res_q.copy_length <= old_len_q;
						ptr_q             <= {1'b0, b_q};
						state_q           <= S_R_W;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_R_W: state_q <= S_R_C;
				S_R_C: begin
					ptr_q   <= head_q;
					state_q <= S_M_W;
				end
				S_M_W: state_q <= S_M_C0;
				S_M_C0: begin
					cur_q <= ptr_q[SLOT_W-1:0];
					ent_q <= rd_q;
					if (rd_q.next[SLOT_W]) begin
						state_q <= S_DONE;
					end else begin
						ptr_q   <= rd_q.next;
						state_q <= S_M_W2;
					end
				end
				S_M_W2: state_q <= S_M_C1;
				S_M_C1: begin
					// absorb the neighbor, or advance to it
					if (merge_ok) begin
						ent_q <= merged;
					end else begin
						cur_q <= ptr_q[SLOT_W-1:0];
						ent_q <= rd_q;
					end
					if (rd_q.next[SLOT_W]) begin
						state_q <= S_DONE;
					end else begin
						ptr_q   <= rd_q.next;
						state_q <= S_M_W2;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### tb/ffha_checker.sv
// Checker for the first-fit heap allocator: predicts each response from the accepted requests.
module ffha_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  ffha_pkg::req_t               in_data,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  ffha_pkg::rsp_t               out_data,
	input  logic                         cfg_wr_en,
	input  logic [ffha_pkg::LIMIT_W-1:0] cfg_wr_data,
	output int                           fail_count,
	output int                           pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import ffha_pkg::*;

	int unsigned blk_start [MAX_BLOCKS];
	int unsigned blk_size [MAX_BLOCKS];
	bit          blk_free [MAX_BLOCKS];
	int unsigned blk_next [MAX_BLOCKS];
	bit          blk_used [MAX_BLOCKS];
	int unsigned head_blk;
	int unsigned brk;
	int unsigned lim;
	rsp_t        rsp_queue [$];

	function automatic int unsigned free_slot();
		for (int i = 0; i < MAX_BLOCKS; i++)
			if (!blk_used[i])
				return i;
		return MAX_BLOCKS;
	endfunction

	function automatic int unsigned locate(int unsigned a);
		int unsigned cur;
		cur = head_blk;
		while (cur < MAX_BLOCKS) begin
			if (blk_start[cur] + HEADER_BYTES == a)
				return cur;
			cur = blk_next[cur];
		end
		return MAX_BLOCKS;
	endfunction

	function automatic void coalesce();
		int unsigned cur, n;
		cur = head_blk;
		while (cur < MAX_BLOCKS) begin
			n = blk_next[cur];
			if (n >= MAX_BLOCKS)
				break;
			if (blk_free[cur] && blk_free[n]) begin
				blk_size[cur] += HEADER_BYTES + blk_size[n];
				blk_next[cur] = blk_next[n];
				blk_used[n] = 0;
			end else begin
				cur = n;
			end
		end
	endfunction

	function automatic logic [2:0] carve(int unsigned sz, output int unsigned a);
		int unsigned cur, last, s, need, cap;
		a = 0;
		cur = head_blk;
		last = MAX_BLOCKS;
		if (sz == 0)
			return ST_ZERO_SIZE;
		while (cur < MAX_BLOCKS) begin
			if (blk_free[cur] && blk_size[cur] >= sz) begin
				blk_free[cur] = 0;
				if (blk_size[cur] > sz + HEADER_BYTES) begin
					s = free_slot();
					if (s < MAX_BLOCKS) begin
						blk_used[s] = 1;
						blk_start[s] = blk_start[cur] + HEADER_BYTES + sz;
						blk_size[s] = blk_size[cur] - sz - HEADER_BYTES;
						blk_free[s] = 1;
						blk_next[s] = blk_next[cur];
						blk_size[cur] = sz;
						blk_next[cur] = s;
					end
				end
				a = blk_start[cur] + HEADER_BYTES;
				return ST_OK;
			end
			last = cur;
			cur = blk_next[cur];
		end
		need = brk + HEADER_BYTES + sz;
		cap = (lim < ARENA_BYTES) ? lim : ARENA_BYTES;
		if (need > cap)
			return ST_EXHAUSTED;
		s = free_slot();
		if (s >= MAX_BLOCKS)
			return ST_TABLE_FULL;
		blk_used[s] = 1;
		blk_start[s] = brk;
		blk_size[s] = sz;
		blk_free[s] = 0;
		blk_next[s] = MAX_BLOCKS;
		if (last >= MAX_BLOCKS)
			head_blk = s;
		else
			blk_next[last] = s;
		brk = need;
		a = blk_start[s] + HEADER_BYTES;
		return ST_OK;
	endfunction

	function automatic rsp_t predict_response(req_t r);
		rsp_t        p;
		int unsigned a, b, res, old_len;
		p = '0;
		res = 0;
		a = r.block_address;
		if (r.command == CMD_ALLOC || (r.command == CMD_REALLOC && a == 0)) begin
			p.status = carve(r.request_size, res);
		end else if (r.command == CMD_FREE) begin
			if (a != 0) begin
				b = locate(a);
				if (b >= MAX_BLOCKS) begin
					p.status = ST_UNKNOWN;
				end else begin
					blk_free[b] = 1;
					coalesce();
				end
			end
		end else if (r.command == CMD_REALLOC) begin
			b = locate(a);
			if (b >= MAX_BLOCKS) begin
				p.status = ST_UNKNOWN;
			end else if (blk_size[b] >= r.request_size) begin
				res = a;
			end else begin
				old_len = blk_size[b];
				p.status = carve(r.request_size, res);
				if (p.status == ST_OK) begin
					p.copy_source = a[15:0];
					p.copy_length = old_len[15:0];
					blk_free[b] = 1;
					coalesce();
				end
			end
		end
		p.result_address = res[15:0];
		return p;
	endfunction

	assign pending = rsp_queue.size();

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < MAX_BLOCKS; i++)
				blk_used[i] = 0;
			head_blk = MAX_BLOCKS;
			brk = 0;
			lim = 65536;
			fail_count <= 0;
			rsp_queue.delete();
		end else begin
			if (cfg_wr_en)
				lim = cfg_wr_data;
			if (in_valid && in_ready)
				rsp_queue.push_back(predict_response(in_data));
			if (out_valid && out_ready) begin
				if (rsp_queue.size() == 0) begin
					$display("%0t: unexpected response %p", $time, out_data);
					fail_count <= fail_count + 1;
				end else begin
					want = rsp_queue.pop_front();
					if (out_data !== want) begin
						$display("%0t: mismatch expected %p actual %p", $time, want, out_data);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

### tb/tb_top.sv
// Testbench top for the first-fit heap allocator: stimulus, idling phases and the verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ffha_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	req_t               in_data;
	logic               out_valid;
	logic               out_ready;
	rsp_t               out_data;
	logic               cfg_wr_en;
	logic [LIMIT_W-1:0] cfg_wr_data;
	int                 fail_count;
	int                 pending;
	int                 send_idle_pct;
	int                 recv_stall_pct;
	logic [15:0]        granted [$];

	first_fit_heap_allocator dut (.*);

	ffha_checker chk (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// Throttle the response side; percentage set per phase.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 0;
		else
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Remember granted addresses so frees and reallocates mostly hit live blocks.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready && out_data.result_address != 0)
			if (granted.size() < 64)
				granted.push_back(out_data.result_address);
	end

	// Hold valid across back-to-back requests; drop it only while idling.
	task automatic send_request(logic [1:0] c, logic [15:0] sz, logic [15:0] a);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		in_valid <= 1;
		in_data <= '{command: c, request_size: sz, block_address: a};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Wait until every response is back, then give the block time to settle.
	task automatic drain();
		in_valid <= 0;
		while (pending != 0)
			@(posedge clk);
		repeat (1200) @(posedge clk);
	endtask

	task automatic write_limit(logic [LIMIT_W-1:0] v);
		cfg_wr_en <= 1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 0;
	endtask

	function automatic logic [15:0] pick_address();
		int k;
		if (granted.size() == 0 || $urandom_range(9) == 0)
			return $urandom_range(1) ? 16'($urandom) : 16'd0;
		k = $urandom_range(granted.size() - 1);
		pick_address = granted[k];
		// Drop it from the list most of the time, keep some for double frees.
		if ($urandom_range(3) != 0)
			granted.delete(k);
	endfunction

	task automatic random_burst(int n, int max_sz);
		logic [1:0] c;
		int         r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			c = (r < 45) ? CMD_ALLOC : (r < 80) ? CMD_FREE : (r < 97) ? CMD_REALLOC
				: CMD_UNUSED;
			if (c == CMD_ALLOC && $urandom_range(49) == 0)
				send_request(c, 16'($urandom), 16'($urandom));
			else
				send_request(c, 16'($urandom_range(max_sz)),
					(c == CMD_ALLOC) ? 16'($urandom) : pick_address());
		end
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		cfg_wr_en = 0;
		cfg_wr_data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: zero size, null free, unknown address, unused command, split, merge.
		send_request(CMD_ALLOC, 16'd0, 16'd0);
		send_request(CMD_FREE, 16'd0, 16'd0);
		send_request(CMD_FREE, 16'd100, 16'hFFFF);
		send_request(CMD_UNUSED, 16'hFFFF, 16'hFFFF);
		send_request(CMD_ALLOC, 16'd100, 16'd0);
		send_request(CMD_ALLOC, 16'd40, 16'd0);
		send_request(CMD_ALLOC, 16'd8, 16'd0);
		send_request(CMD_FREE, 16'd0, 16'd24);
		send_request(CMD_FREE, 16'd0, 16'd24);
		send_request(CMD_ALLOC, 16'd10, 16'd0);
		send_request(CMD_REALLOC, 16'd0, 16'd24);
		send_request(CMD_REALLOC, 16'd500, 16'd24);
		send_request(CMD_REALLOC, 16'd30, 16'd0);
		send_request(CMD_REALLOC, 16'd30, 16'd12345);
		send_request(CMD_FREE, 16'd0, 16'd148);
		send_request(CMD_ALLOC, 16'hFFFF, 16'd0);
		send_request(CMD_ALLOC, 16'd60000, 16'd0);
		drain();

		// Limit extremes: zero, all ones (above the arena), then 3000.
		write_limit(17'd0);
		send_request(CMD_ALLOC, 16'd1, 16'd0);
		drain();
		write_limit(17'h1FFFF);
		drain();
		write_limit(17'd3000);

		// Allocate four one-byte blocks under the 3000-byte limit.
		granted.delete();
		for (int i = 0; i < 4; i++)
			send_request(CMD_ALLOC, 16'd1, 16'd0);
		drain();

		// Phases: no idling, sender idle, receiver stall, both.
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1) ? 64 : (ph == 3) ? 28 : 0;
			recv_stall_pct = (ph == 2) ? 64 : (ph == 3) ? 28 : 0;
			write_limit((ph == 0) ? 17'd65536 : (ph == 1) ? 17'd20000 : (ph == 2) ? 17'd4096
				: 17'd65535);
			random_burst(100, (ph == 2) ? 200 : 2000);
			random_burst(40, 65535);
			drain();
		end
		// Exhaust the table: 270 allocations of one to four bytes under a full limit.
		write_limit(17'd65536);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int i = 0; i < 270; i++)
			send_request(CMD_ALLOC, 16'($urandom_range(1, 4)), 16'd0);
		drain();

		if (fail_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	initial begin
		#400ms;
		$display("tb_top: errors");
		$finish;
	end

endmodule

### sim.f
src/ffha_pkg.sv
src/ffha_slot_finder.sv
src/first_fit_heap_allocator.sv
tb/ffha_checker.sv
tb/tb_top.sv
